### rtl/sha256_stream_hasher_assert.svh
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication checked on every edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/sha_pkg.sv
// shared types, constants and functions of the sha-256 stream hasher
package sha_pkg;

    typedef enum logic [1:0] {
        FUNC_ABSORB   = 2'd0,
        FUNC_FINALIZE = 2'd1,
        FUNC_RESTART  = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // control from the sequencer to the round engine
    typedef struct packed {
        logic start;
        logic init;
    } eng_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

endpackage

### rtl/sha_engine.sv
// round engine: message schedule window, working variables and chaining memory
module sha_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::eng_ctl_t ctl,
    input  logic [31:0]       msg_word,
    output logic [3:0]        msg_addr,
    input  logic [2:0]        rd_idx,
    output logic [31:0]       rd_word,
    output sha_pkg::eng_sts_t sts
);
    import sha_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_LOAD,
        E_ROUND,
        E_ADD
    } eng_state_t;

    logic [31:0] hash_mem [8];
    logic [31:0] hash_q;
    logic [2:0]  hash_raddr;
    logic        hash_we;
    logic [2:0]  hash_waddr;
    logic [31:0] hash_wdata;

    eng_state_t  st_reg, st_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] s0, s1, wt, t1, t2;

    function automatic logic [31:0] add_v_prev(input logic [2:0] c);
        logic [31:0] r;
        case (c)
            3'd1: r = a_reg;
            3'd2: r = b_reg;
            3'd3: r = c_reg;
            3'd4: r = d_reg;
            3'd5: r = e_reg;
            3'd6: r = f_reg;
            default: r = g_reg;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (hash_we)
        begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        hash_q <= hash_mem[hash_raddr];
    end

    assign rd_word  = hash_q;
    assign msg_addr = cnt_next[3:0];

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            E_IDLE:
            begin
                cnt_next = '0;
                if (ctl.start)
                begin
                    st_next = E_LOAD;
                end
            end
            E_LOAD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    st_next = E_ROUND;
                    cnt_next = '0;
                end
            end
            E_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    st_next = E_ADD;
                    cnt_next = '0;
                end
            end
            E_ADD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    st_next = E_IDLE;
                    cnt_next = '0;
                end
            end
            default: st_next = E_IDLE;
        endcase
    end

    // message word for the round: first 16 come straight from the block buffer
    assign s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wt = (cnt_reg < 7'd16) ? msg_word : (w_reg[0] + s0 + w_reg[9] + s1);
    assign t1 = h_reg + (ror32(e_reg, 6) ^ ror32(e_reg, 11) ^ ror32(e_reg, 25))
              + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(cnt_reg[5:0]) + wt;
    assign t2 = (ror32(a_reg, 2) ^ ror32(a_reg, 13) ^ ror32(a_reg, 22))
              + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    always_comb
    begin
        hash_raddr = cnt_reg[2:0];
        if (st_reg == E_IDLE)
        begin
            hash_raddr = rd_idx;
        end
        hash_we = 1'b0;
        hash_waddr = cnt_reg[2:0];
        hash_wdata = iv_word(cnt_reg[2:0]);
        if (st_reg == E_IDLE && ctl.init)
        begin
            hash_we = 1'b1;
            hash_waddr = rd_idx;
            hash_wdata = iv_word(rd_idx);
        end
        else if (st_reg == E_ADD && cnt_reg != 7'd0)
        begin
            hash_we = 1'b1;
            hash_waddr = cnt_reg[2:0] - 3'd1;
            hash_wdata = hash_q + ((cnt_reg == 7'd8) ? h_reg : add_v_prev(cnt_reg[2:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= E_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // load shifts chaining words in through h; rounds shift the schedule window
    always_ff @(posedge clk)
    begin
        if (st_reg == E_LOAD && cnt_reg != 7'd0)
        begin
            a_reg <= b_reg; b_reg <= c_reg; c_reg <= d_reg; d_reg <= e_reg;
            e_reg <= f_reg; f_reg <= g_reg; g_reg <= h_reg; h_reg <= hash_q;
        end
        else if (st_reg == E_ROUND)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
    end

    assign sts.busy = (st_reg != E_IDLE);
    assign sts.done = (st_reg == E_ADD) && (cnt_reg == 7'd8);
endmodule

### rtl/sha256_stream_hasher.sv
// top level: byte collection, padding sequencer and digest output
// Each data byte is written into the 64-byte block memory; the 64th byte
// of a block starts the round engine, which loads the chaining words, runs
// 64 rounds (one round per cycle) and then updates the chaining memory; no
// item is accepted while it runs. Finalize writes the padding one byte per
// cycle (plus one extra block when fewer than 9 bytes are free), then emits
// eight digest items, each read from the chaining memory and registered and
// held until the receiver takes it; a finalize on a closed message only
// emits. Restart rewrites the eight initial chaining words.
module sha256_stream_hasher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sha_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sha_pkg::out_item_t out_item
);
    import sha_pkg::*;

    logic [31:0] blk_mem [16];
    logic        blk_we;
    logic [5:0]  blk_waddr;
    logic [7:0]  blk_wdata;
    logic [31:0] blk_q;
    logic [3:0]  msg_addr;
    logic [31:0] msg_word;
    logic [2:0]  rd_idx;
    logic [31:0] rd_word;
    eng_ctl_t    ctl;
    eng_sts_t    sts;

    state_t      st_reg, st_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic        fin_reg, fin_next;
    logic        last_blk_reg, last_blk_next;
    logic [2:0]  idx_reg, idx_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [63:0] bits;
    logic        take;

    // padding bookkeeping: marker byte written yet, and length placed in this block
    logic mark_done_reg, mark_done_next;
    logic bits_placed_reg, bits_placed_next;

    logic        ov_reg;
    logic [31:0] ow_reg;
    logic [2:0]  oi_reg;

    // block memory, one big-endian word per entry, written a byte at a time
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr[5:2]][{~blk_waddr[1:0], 3'b000} +: 8] <= blk_wdata;
        end
        blk_q <= blk_mem[msg_addr];
    end
    assign msg_word = blk_q;

    sha_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .msg_word (msg_word),
        .msg_addr (msg_addr),
        .rd_idx   (rd_idx),
        .rd_word  (rd_word),
        .sts      (sts)
    );

    assign bits = {total_reg, 3'b000};
    assign take = in_valid && !in_stall;
    assign in_stall = (st_reg != ST_IDLE);

    always_comb
    begin
        st_next = st_reg;
        fill_next = fill_reg;
        total_next = total_reg;
        fin_next = fin_reg;
        last_blk_next = last_blk_reg;
        idx_next = idx_reg;
        case (st_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (take)
                begin
                    case (in_item.func)
                        FUNC_ABSORB:
                        begin
                            if (!fin_reg)
                            begin
                                total_next = total_reg + 61'd1;
                                fill_next = fill_reg + 6'd1;
                                if (fill_reg == 6'd63)
                                begin
                                    last_blk_next = 1'b0;
                                    st_next = ST_LOAD;
                                end
                            end
                        end
                        FUNC_FINALIZE:
                        begin
                            st_next = fin_reg ? ST_EMIT : ST_PAD;
                        end
                        FUNC_RESTART:
                        begin
                            fill_next = '0;
                            total_next = '0;
                            fin_next = 1'b0;
                            st_next = ST_INIT;
                        end
                        default: st_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                // first byte is 0x80 (marked by mark_done), then zeros, then length
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    last_blk_next = 1'b1;
                    st_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                st_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (sts.done)
                begin
                    if (!last_blk_reg)
                    begin
                        st_next = ST_IDLE;
                    end
                    else if (bits_placed_reg)
                    begin
                        fin_next = 1'b1;
                        st_next = ST_EMIT;
                    end
                    else
                    begin
                        st_next = ST_PAD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_valid && !out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mark_done_next = mark_done_reg;
        bits_placed_next = bits_placed_reg;
        blk_we = 1'b0;
        blk_waddr = fill_reg;
        blk_wdata = in_item.data_byte;
        ctl.start = (st_reg == ST_LOAD);
        ctl.init = (st_reg == ST_INIT);
        rd_idx = idx_reg;
        if (st_reg == ST_IDLE)
        begin
            mark_done_next = 1'b0;
            bits_placed_next = 1'b0;
            if (take && in_item.func == FUNC_ABSORB && !fin_reg)
            begin
                blk_we = 1'b1;
            end
        end
        else if (st_reg == ST_PAD)
        begin
            blk_we = 1'b1;
            mark_done_next = 1'b1;
            if (!mark_done_reg)
            begin
                blk_wdata = 8'h80;
                if (fill_reg < 6'd56)
                begin
                    bits_placed_next = 1'b1;
                end
            end
            else
            begin
                blk_wdata = 8'h00;
                if (fill_reg == 6'd0)
                begin
                    bits_placed_next = 1'b1;
                end
            end
            if (fill_reg >= 6'd56 && bits_placed_next)
            begin
                blk_wdata = bits[8*(63 - fill_reg) +: 8];
            end
        end
    end

    // digest word read: the chaining memory is registered, so its data arrives in the cycle after the address
    always_comb
    begin
        rd_pend_next = 1'b0;
        if (st_reg == ST_EMIT && !(out_valid && !out_stall))
        begin
            rd_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_INIT;
            fill_reg <= '0;
            total_reg <= '0;
            fin_reg <= 1'b0;
            last_blk_reg <= 1'b0;
            idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            mark_done_reg <= 1'b0;
            bits_placed_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
            fin_reg <= fin_next;
            last_blk_reg <= last_blk_next;
            idx_reg <= idx_next;
            rd_pend_reg <= rd_pend_next;
            mark_done_reg <= mark_done_next;
            bits_placed_reg <= bits_placed_next;
            if (out_valid && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            else if (st_reg == ST_EMIT && rd_pend_reg && !ov_reg)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_EMIT && rd_pend_reg && !ov_reg)
        begin
            ow_reg <= rd_word;
            oi_reg <= idx_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_item.digest_word = ow_reg;
    assign out_item.word_index = oi_reg;
    assign out_item.last = (oi_reg == 3'd7);
endmodule

### rtl/sha_checker.sv
// port-level assertions for the sha-256 stream hasher and their binding
`include "sha256_stream_hasher_assert.svh"
module sha_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input sha_pkg::out_item_t out_item
);
    import sha_pkg::*;

    `SHA_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid, out_item.last == &out_item.word_index)
    `SHA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    `SHA_ASSERT_IMP(a_no_take_emit, clk, rst_n, out_valid, in_stall)
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

### verif/sha256_stream_hasher_tb.sv
// self-checking testbench for the streaming sha-256 hasher
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 1000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    sha256_stream_hasher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // predictor state
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] msg_len;
    bit          closed;

    in_item_t    pending_items [$];
    out_item_t   digest_words [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          pause_send;
    bit          hold_go;
    bit          long_hold;
    bit          in_taken;
    int          gap_draw;
    int          send_gap;
    int          recv_gap;

    const logic [31:0] k_tab [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    const logic [31:0] h_init [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic clear_hasher();
        for (int i = 0; i < 8; i++)
            chain[i] = h_init[i];
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        fill = 0;
        msg_len = '0;
        closed = 0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                + k_tab[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic predict_digest(input in_item_t it);
        logic [63:0] bits;
        out_item_t   o;
        case (func_t'(it.func))
            FUNC_ABSORB:
            begin
                if (!closed)
                begin
                    msg_len = msg_len + 61'd1;
                    blk[fill] = it.data_byte;
                    fill++;
                    if (fill == 64)
                    begin
                        compress_block();
                        fill = 0;
                    end
                end
            end
            FUNC_FINALIZE:
            begin
                if (!closed)
                begin
                    bits = {msg_len, 3'b000};
                    blk[fill] = 8'h80;
                    fill++;
                    if (fill > 56)
                    begin
                        for (int i = fill; i < 64; i++)
                            blk[i] = 8'h00;
                        compress_block();
                        fill = 0;
                    end
                    for (int i = fill; i < 56; i++)
                        blk[i] = 8'h00;
                    for (int i = 0; i < 8; i++)
                        blk[56+i] = bits[63-8*i -: 8];
                    compress_block();
                    fill = 0;
                    closed = 1;
                end
                for (int i = 0; i < 8; i++)
                begin
                    o.digest_word = chain[i];
                    o.word_index = i[2:0];
                    o.last = (i == 7);
                    digest_words.push_back(o);
                end
            end
            FUNC_RESTART:
                clear_hasher();
            default:
            begin
            end
        endcase
    endtask

    function automatic in_item_t mk(input func_t fn, input logic [7:0] db);
        in_item_t it;
        it.func = fn;
        it.data_byte = db;
        return it;
    endfunction

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            pending_items.push_back(mk(FUNC_ABSORB, 8'($urandom_range(0, 255))));
    endtask

    always #5 clk = ~clk;

    // input acceptance as seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            in_item <= '0;
            send_gap <= 0;
        end
        else if (in_taken)
        begin
            predict_digest(in_item);
            gap_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            if (gap_draw == 0 && pending_items.size() > 0 && !pause_send)
                in_item <= pending_items.pop_front();
            else
            begin
                in_valid <= 0;
                send_gap <= (gap_draw > 0) ? gap_draw - 1 : 0;
            end
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_items.size() > 0 && !pause_send)
            begin
                in_valid <= 1;
                in_item <= pending_items.pop_front();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_words.size() == 0)
            begin
                $error("unexpected item: digest_word %h", out_item.digest_word);
                fail_count++;
            end
            else
            begin
                if (out_item.digest_word !== digest_words[0].digest_word)
                begin
                    $error("digest_word expected %h actual %h",
                        digest_words[0].digest_word, out_item.digest_word);
                    fail_count++;
                end
                if (out_item.word_index !== digest_words[0].word_index)
                begin
                    $error("word_index expected %0d actual %0d",
                        digest_words[0].word_index, out_item.word_index);
                    fail_count++;
                end
                if (out_item.last !== digest_words[0].last)
                begin
                    $error("last expected %0d actual %0d",
                        digest_words[0].last, out_item.last);
                    fail_count++;
                end
                void'(digest_words.pop_front());
            end
        end
    end

    // long receiver hold
    initial
    begin
        long_hold = 0;
        wait (hold_go);
        @(posedge clk);
        long_hold = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 0;
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            recv_gap <= 0;
        end
        else if (long_hold)
        begin
            out_stall <= 1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1;
        end
        else
        begin
            out_stall <= 0;
            if ($urandom_range(0, 3) == 0)
                recv_gap <= $urandom_range(0, 14);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int len;
        int picked;
        rst_n = 0;
        pause_send = 0;
        hold_go = 0;
        clear_hasher();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty message, repeat finalize, ignored items, restart
        pending_items.push_back(mk(FUNC_FINALIZE, 8'h00));
        pending_items.push_back(mk(FUNC_FINALIZE, 8'hff));
        pending_items.push_back(mk(FUNC_ABSORB, 8'hff));
        pending_items.push_back(mk(FUNC_FINALIZE, 8'h00));
        pending_items.push_back(mk(FUNC_RESTART, 8'hff));
        pending_items.push_back(mk(FUNC_ABSORB, 8'h00));
        pending_items.push_back(mk(FUNC_NONE, 8'hff));
        pending_items.push_back(mk(FUNC_ABSORB, 8'hff));
        pending_items.push_back(mk(FUNC_ABSORB, 8'h55));
        pending_items.push_back(mk(FUNC_FINALIZE, 8'h00));
        pending_items.push_back(mk(FUNC_RESTART, 8'h00));
        wait (pending_items.size() == 0);

        // long receiver hold while the sender keeps going
        hold_go = 1;
        pending_items.push_back(mk(FUNC_RESTART, 8'h00));
        queue_message(56);
        pending_items.push_back(mk(FUNC_FINALIZE, 8'h00));
        pending_items.push_back(mk(FUNC_RESTART, 8'h00));
        queue_message(3);
        pending_items.push_back(mk(FUNC_FINALIZE, 8'h00));
        pending_items.push_back(mk(FUNC_RESTART, 8'h00));
        wait (pending_items.size() == 0);

        // sender pauses until all digests are drained
        pause_send = 1;
        wait (digest_words.size() == 0 && !in_valid);
        pause_send = 0;

        // random messages: mostly well formed, some noise
        for (int m = 0; m < 8; m++)
        begin
            picked = $urandom_range(0, 9);
            if (picked < 3)
                len = $urandom_range(54, 66);
            else if (picked < 4)
                len = $urandom_range(100, 130);
            else
                len = $urandom_range(0, 20);
            queue_message(len);
            if ($urandom_range(0, 5) == 0)
                pending_items.push_back(mk(FUNC_NONE, 8'($urandom_range(0, 255))));
            pending_items.push_back(mk(FUNC_FINALIZE, 8'($urandom_range(0, 255))));
            if ($urandom_range(0, 2) == 0)
            begin
                pending_items.push_back(mk(FUNC_ABSORB, 8'($urandom_range(0, 255))));
                pending_items.push_back(mk(FUNC_FINALIZE, 8'($urandom_range(0, 255))));
            end
            pending_items.push_back(mk(FUNC_RESTART, 8'($urandom_range(0, 255))));
        end
        wait (pending_items.size() == 0);
        @(negedge clk);
        wait (!in_valid);
        wait (digest_words.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
